FILE: hw/rtl/sitd_pkg.sv
// shared constants and types for the signed integer to decimal text converter
package sitd_pkg;

   localparam int VALUE_W = 32;
   localparam int CHAR_W  = 8;
   localparam int DIGIT_W = 4;
   localparam int NUM_DIGITS = 10;
   localparam int BCD_W   = NUM_DIGITS * DIGIT_W;
   localparam int CNT_W   = $clog2(VALUE_W);
   localparam int IDX_W   = $clog2(NUM_DIGITS);

   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

   // packed bcd result handed from the converter to the character emitter
   typedef struct packed {
      logic             done;
      logic [BCD_W-1:0] bcd;
   } conv_result_type;

endpackage

FILE: hw/rtl/signed_int_to_decimal_ascii.sv
// top level: signed 32-bit integer to decimal ascii character stream
//
// usage
//   req_* takes one signed 32-bit value per transfer. rsp_* returns its
//   decimal text one ascii character per transfer, most significant first:
//   a leading '-' for negative values, no leading zeros, "0" for zero.
//   rsp_tlast marks the final character of each number.
// conversion and throughput
//   after a req transfer the magnitude runs through a shift-and-add-3
//   binary to bcd loop, one bit per cycle. once the loop's done flag is
//   registered the emitter loads the digits and the first character is
//   valid, then one character per cycle while rsp_tready is high. the
//   block takes one number at a time: req_tready is high only while
//   idle, so no new number is taken until the last character is taken.
// reset
//   synchronous active-high reset returns to idle and drops rsp_tvalid.
// stalls
//   with rsp_tready low the current character and rsp_tlast hold; the
//   block stays busy and req_tready stays low until the last character
//   has been taken.
module signed_int_to_decimal_ascii (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic signed [sitd_pkg::VALUE_W-1:0] req_tdata,  // [31:0] value
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sitd_pkg::CHAR_W-1:0]        rsp_tdata,   // [7:0] character
   output logic                               rsp_tlast
);

   // one-hot sequencer states
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CONV = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type                        state_ff, state_in;
   logic                             neg_ff, neg_in;
   logic                             req_xfer;
   logic [sitd_pkg::VALUE_W-1:0]     mag;
   sitd_pkg::conv_result_type        conv;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   // two's complement magnitude; the most negative value maps to 2^31 unsigned
   assign mag = req_tdata[sitd_pkg::VALUE_W-1] ? (32'd0 - req_tdata) : req_tdata;

   always_comb begin
      state_in = state_ff;
      neg_in   = neg_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               neg_in   = req_tdata[sitd_pkg::VALUE_W-1];
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (conv.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // done once the final character has been taken
            if (rsp_tvalid && rsp_tready && rsp_tlast) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         neg_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         neg_ff   <= neg_in;
      end
   end

   // shift / add-3 binary to bcd unit
   sitd_dabble u_dabble (
      .clock  (clock),
      .reset  (reset),
      .start  (req_xfer),
      .mag    (mag),
      .result (conv)
   );

   // output sequencer and result register
   sitd_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .conv       (conv),
      .negative   (neg_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: hw/rtl/sitd_dabble.sv
// binary to bcd converter: one shift-and-add-3 step per cycle
module sitd_dabble (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [sitd_pkg::VALUE_W-1:0]       mag,
   output sitd_pkg::conv_result_type          result
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [sitd_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic [sitd_pkg::VALUE_W-1:0]    bin_ff, bin_in;
   logic [sitd_pkg::BCD_W-1:0]      bcd_ff, bcd_in;
   logic [sitd_pkg::BCD_W-1:0]      adj;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < sitd_pkg::NUM_DIGITS; i++) begin
         if (bcd_ff[i*sitd_pkg::DIGIT_W +: sitd_pkg::DIGIT_W] >= 4'd5) begin
            adj[i*sitd_pkg::DIGIT_W +: sitd_pkg::DIGIT_W] =
               bcd_ff[i*sitd_pkg::DIGIT_W +: sitd_pkg::DIGIT_W] + 4'd3;
         end else begin
            adj[i*sitd_pkg::DIGIT_W +: sitd_pkg::DIGIT_W] =
               bcd_ff[i*sitd_pkg::DIGIT_W +: sitd_pkg::DIGIT_W];
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         bin_in  = mag;
         bcd_in  = '0;
      end else if (busy_ff) begin
         bcd_in = {adj[sitd_pkg::BCD_W-2:0], bin_ff[sitd_pkg::VALUE_W-1]};
         bin_in = {bin_ff[sitd_pkg::VALUE_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == sitd_pkg::CNT_W'(sitd_pkg::VALUE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign result.done = done_ff;
   assign result.bcd  = bcd_ff;

endmodule

FILE: hw/rtl/sitd_emit.sv
// character emitter: sign, then significant digits most significant first
module sitd_emit (
   input  logic                               clock,
   input  logic                               reset,
   input  sitd_pkg::conv_result_type          conv,
   input  logic                               negative,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sitd_pkg::CHAR_W-1:0]        rsp_tdata,
   output logic                               rsp_tlast
);

   logic                             active_ff, active_in;
   logic                             sign_ff, sign_in;
   logic [sitd_pkg::IDX_W-1:0]       idx_ff, idx_in;
   logic [sitd_pkg::DIGIT_W-1:0]     digit_ff [sitd_pkg::NUM_DIGITS];
   logic [sitd_pkg::IDX_W-1:0]       top_idx;
   logic [sitd_pkg::DIGIT_W-1:0]     cur_digit;
   logic                             xfer;

   // highest nonzero digit, zero gives the lowest digit
   always_comb begin
      top_idx = '0;
      for (int i = 0; i < sitd_pkg::NUM_DIGITS; i++) begin
         if (conv.bcd[i*sitd_pkg::DIGIT_W +: sitd_pkg::DIGIT_W] != '0) begin
            top_idx = sitd_pkg::IDX_W'(i);
         end
      end
   end

   assign cur_digit  = digit_ff[idx_ff];
   assign xfer       = active_ff && rsp_tready;
   assign rsp_tvalid = active_ff;
   assign rsp_tdata  = sign_ff ? sitd_pkg::ASCII_MINUS
                               : sitd_pkg::ASCII_ZERO + {4'b0000, cur_digit};
   assign rsp_tlast  = !sign_ff && (idx_ff == '0);

   always_comb begin
      active_in = active_ff;
      sign_in   = sign_ff;
      idx_in    = idx_ff;
      if (conv.done) begin
         active_in = 1'b1;
         sign_in   = negative;
         idx_in    = top_idx;
      end else if (xfer) begin
         if (sign_ff) begin
            sign_in = 1'b0;
         end else if (idx_ff == '0) begin
            active_in = 1'b0;
         end else begin
            idx_in = idx_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         sign_ff   <= 1'b0;
         idx_ff    <= '0;
      end else begin
         active_ff <= active_in;
         sign_ff   <= sign_in;
         idx_ff    <= idx_in;
      end
      if (conv.done) begin
         for (int i = 0; i < sitd_pkg::NUM_DIGITS; i++) begin
            digit_ff[i] <= conv.bcd[i*sitd_pkg::DIGIT_W +: sitd_pkg::DIGIT_W];
         end
      end
   end

endmodule

FILE: dv/signed_int_to_decimal_ascii_test.sv
// testbench for the signed integer to decimal ascii converter
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_test;

   // longest stretch with no transfer on either side before giving up
   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_COUNT = 140;
   // drain time after the last expected character, about one number's latency
   localparam int DRAIN_CYCLES = 50;
   localparam int MAX_CHARS    = 11;

   // one expected character of the text stream
   typedef struct packed {
      logic [sitd_pkg::CHAR_W-1:0] character;
      logic                        last;
   } char_exp_type;

   // directed stimulus row: an empty text means the predictor supplies it
   typedef struct {
      logic [sitd_pkg::VALUE_W-1:0] value;
      string                        text;
   } directed_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [sitd_pkg::VALUE_W-1:0]  req_tdata = '0;  // [31:0] value
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [sitd_pkg::CHAR_W-1:0]   rsp_tdata;       // [7:0] character
   logic                          rsp_tlast;

   char_exp_type pending_chars[$];
   int          failures = 0;
   int          numbers_sent = 0;
   int          chars_checked = 0;
   int          full_width_runs = 0;
   int          run_length = 0;
   int          stall_left = 0;
   int          idle_cycles = 0;
   bit          quiet_phase = 1'b0;

   // extremes, digit-count boundaries and a couple of bit patterns
   directed_row_type directed_rows [22] = '{
      '{32'd0,          "0"},
      '{32'd1,          "1"},
      '{-1,             "-1"},
      '{32'd9,          "9"},
      '{-9,             "-9"},
      '{32'd10,         "10"},
      '{-10,            "-10"},
      '{32'd99,         ""},
      '{32'd100,        ""},
      '{32'd7,          ""},
      '{-7,             ""},
      '{32'h7FFF_FFFF,  "2147483647"},
      '{32'h8000_0000,  "-2147483648"},
      '{32'h8000_0001,  "-2147483647"},
      '{32'd1000000000, "1000000000"},
      '{-1000000000,    "-1000000000"},
      '{32'd999999999,  ""},
      '{-999999999,     ""},
      '{32'd1234567890, ""},
      '{-987654321,     ""},
      '{32'h5555_5555,  ""},
      '{32'hAAAA_AAAA,  ""}
   };

   signed_int_to_decimal_ascii dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // queue the decimal text of one value: sign, then digits msd first
   function automatic void render_decimal(input logic [sitd_pkg::VALUE_W-1:0] value);
      logic [sitd_pkg::VALUE_W-1:0] magnitude;
      logic [3:0]                   digits [sitd_pkg::NUM_DIGITS];
      int                           count;
      int                           k;
      // unsigned negate keeps the most negative value intact
      magnitude = value[sitd_pkg::VALUE_W-1] ? -value : value;
      count = 0;
      do begin
         digits[count] = 4'(magnitude % 10);
         magnitude = magnitude / 10;
         count++;
      end while (magnitude != 0);
      if (value[sitd_pkg::VALUE_W-1])
         pending_chars.push_back('{sitd_pkg::ASCII_MINUS, 1'b0});
      for (k = count - 1; k >= 0; k--)
         pending_chars.push_back('{sitd_pkg::ASCII_ZERO + sitd_pkg::CHAR_W'(digits[k]),
                                   k == 0});
   endfunction

   // queue a hand-written text as the expected characters
   function automatic void queue_text(input string text);
      int k;
      for (k = 0; k < text.len(); k++)
         pending_chars.push_back('{text[k], k == text.len() - 1});
   endfunction

   // random values spread across every digit count and both signs
   function automatic logic [sitd_pkg::VALUE_W-1:0] pick_value();
      int unsigned                  ten_pow;
      logic [sitd_pkg::VALUE_W-1:0] magnitude;
      ten_pow = 10 ** $urandom_range(1, 9);
      case ($urandom_range(0, 3))
         0: begin
            return $urandom();
         end
         1: begin
            magnitude = $urandom_range(0, ten_pow - 1);
         end
         2: begin
            // one below, at, or one above a power of ten
            magnitude = ten_pow + $urandom_range(0, 2) - 1;
         end
         default: begin
            magnitude = $urandom_range(0, 99);
         end
      endcase
      return $urandom_range(0, 1) ? -magnitude : magnitude;
   endfunction

   // present one number, holding tvalid until the transfer
   task automatic send_number(input logic [sitd_pkg::VALUE_W-1:0] value,
                              input string text);
      int gap;
      gap = quiet_phase ? 0 : $urandom_range(0, 17);
      // only lower tvalid when a gap follows, so tvalid never toggles within a step
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (text.len() != 0)
         queue_text(text);
      else
         render_decimal(value);
      numbers_sent++;
   endtask

   task automatic check_character(input logic [sitd_pkg::CHAR_W-1:0] got_char,
                                  input logic got_last);
      char_exp_type want;
      if (pending_chars.size() == 0) begin
         $error("unexpected character transfer: character %h last %b", got_char, got_last);
         failures++;
      end else begin
         want = pending_chars.pop_front();
         if (got_char !== want.character) begin
            $error("character: expected %h, actual %h", want.character, got_char);
            failures++;
         end
         if (got_last !== want.last) begin
            $error("last: expected %b, actual %b", want.last, got_last);
            failures++;
         end
      end
      chars_checked++;
      run_length++;
      if (got_last) begin
         if (run_length == MAX_CHARS) full_width_runs++;
         run_length = 0;
      end
   endtask

   // receiving side: each character gets its own stall, counted in valid cycles
   // so that stalls land on first, middle and last characters alike
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         check_character(rsp_tdata, rsp_tlast);
         stall_left = quiet_phase ? 0 : $urandom_range(0, 17);
      end
      if (stall_left != 0) begin
         if (rsp_tvalid) stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog on cycles with no transfer at all
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int k;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      for (k = 0; k < $size(directed_rows); k++)
         send_number(directed_rows[k].value, directed_rows[k].text);

      // random part, in blocks; some blocks run back to back with no idling
      for (k = 0; k < RANDOM_COUNT; k++) begin
         if (k % 20 == 0)
            quiet_phase = (k == 40) || ($urandom_range(0, 3) == 0);
         send_number(pick_value(), "");
      end
      req_tvalid <= 1'b0;
      quiet_phase = 1'b0;

      while (pending_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pending_chars.size() != 0) begin
         $error("%0d expected characters never arrived", pending_chars.size());
         failures++;
      end
      $display("covered %0d numbers, %0d characters checked, %0d eleven-character runs",
               numbers_sent, chars_checked, full_width_runs);
      if (failures == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/sitd_pkg.sv
hw/rtl/sitd_dabble.sv
hw/rtl/sitd_emit.sv
hw/rtl/signed_int_to_decimal_ascii.sv
dv/signed_int_to_decimal_ascii_test.sv
